/* design/round_robin_thread_scheduler_core_defines.svh */
// Assertion macros shared by the round-robin scheduler RTL.
// Depends on nothing; users must have signals named clk and rst_n in scope.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");
`define RRTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");
`else
`define RRTS_ASSERT_IMP(label, ante, cons)
`define RRTS_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* design/rrts_pkg.sv */
// Shared types and constants of the round-robin thread scheduler.
// Used by the interfaces, the controller, the datapath and the top level.
package rrts_pkg;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 16;
    localparam int SLEEP_W  = 16;
    localparam int STATUS_W = 4;
    localparam int RSLOT_W  = 5;
    localparam int QUANT_W  = 16;
    localparam int MODE_W   = 3;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd200;
    localparam logic [PADDR_W-3:0] REG_QUANTUM   = 1'b0;

    // command kinds
    localparam logic [KIND_W-1:0] K_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] K_CREATE  = 3'd1;
    localparam logic [KIND_W-1:0] K_EXIT    = 3'd2;
    localparam logic [KIND_W-1:0] K_YIELD   = 3'd3;
    localparam logic [KIND_W-1:0] K_SUSPEND = 3'd4;
    localparam logic [KIND_W-1:0] K_RESUME  = 3'd5;
    localparam logic [KIND_W-1:0] K_KILL    = 3'd6;
    localparam logic [KIND_W-1:0] K_SLEEP   = 3'd7;

    // slot modes
    localparam logic [MODE_W-1:0] M_DEAD  = 3'd0;
    localparam logic [MODE_W-1:0] M_READY = 3'd1;
    localparam logic [MODE_W-1:0] M_RUN   = 3'd2;
    localparam logic [MODE_W-1:0] M_SUSP  = 3'd3;
    localparam logic [MODE_W-1:0] M_SLEEP = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] ST_DONE     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_SWITCH   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_KEPT     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_WAIT     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SUSPHALT = 4'd4;
    localparam logic [STATUS_W-1:0] ST_FINHALT  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NOCREATE = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 4'd7;
    localparam logic [STATUS_W-1:0] ST_HALTED   = 4'd8;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LATCH     = 4'd1;
    localparam logic [3:0] OP_TICK      = 4'd2;
    localparam logic [3:0] OP_SCAN_INIT = 4'd3;
    localparam logic [3:0] OP_RD_CUR    = 4'd4;
    localparam logic [3:0] OP_SET_CUR   = 4'd5;
    localparam logic [3:0] OP_HIT_MODE  = 4'd6;
    localparam logic [3:0] OP_CREATE_WR = 4'd7;
    localparam logic [3:0] OP_DISP_OLD  = 4'd8;
    localparam logic [3:0] OP_DISP_NEW  = 4'd9;
    localparam logic [3:0] OP_KEEP      = 4'd10;
    localparam logic [3:0] OP_LOAD_OUT  = 4'd11;

    // scan match kinds
    localparam logic [1:0] SK_DISP   = 2'd0;
    localparam logic [1:0] SK_DEAD   = 2'd1;
    localparam logic [1:0] SK_RESUME = 2'd2;
    localparam logic [1:0] SK_KILL   = 2'd3;

    typedef struct packed {
        logic [3:0]          op;
        logic [1:0]          skind;
        logic [MODE_W-1:0]   mode_wdata;
        logic                wake_we;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic scan_hit;
        logic hit_is_cur;
        logic cur_run;
        logic yield_due;
        logic saw_sleep;
        logic saw_susp;
    } stat_t;

endpackage

/* design/rrts_req_if.sv */
// Request channel of the scheduler: valid/ready plus command payload.
// Depends on rrts_pkg for field widths.
interface rrts_req_if;
    logic                         valid;
    logic                         ready;
    logic [rrts_pkg::KIND_W-1:0]  kind;
    logic [rrts_pkg::ID_W-1:0]    target_id;
    logic [rrts_pkg::SLEEP_W-1:0] sleep_ms;

    modport source (output valid, output kind, output target_id, output sleep_ms,
                    input ready);
    modport sink   (input valid, input kind, input target_id, input sleep_ms,
                    output ready);
endinterface

/* design/rrts_rsp_if.sv */
// Result channel of the scheduler: valid/ready plus result payload.
// Depends on rrts_pkg for field widths.
interface rrts_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rrts_pkg::STATUS_W-1:0] status;
    logic [rrts_pkg::RSLOT_W-1:0]  running_slot;
    logic [rrts_pkg::ID_W-1:0]     running_id;
    logic [rrts_pkg::ID_W-1:0]     created_id;

    modport source (output valid, output status, output running_slot,
                    output running_id, output created_id, input ready);
    modport sink   (input valid, input status, input running_slot,
                    input running_id, input created_id, output ready);
endinterface

/* design/round_robin_thread_scheduler_core.sv */
// Top level of the round-robin thread scheduler.
// Depends on rrts_pkg, rrts_req_if, rrts_rsp_if, rrts_ctrl and rrts_dpath.
//
// Usage:
//   req  - command request (kind, target_id, sleep_ms), valid/ready.
//   rsp  - one result per request (status, running_slot, running_id,
//          created_id), valid/ready, held in an output register.
//   APB  - register 0 at byte address 0 is quantum_ms (reset 200); writes
//          land on the edge with psel, penable, pwrite high. pready is tied
//          high. Write it only while no request is in flight.
// Sequence: a tick without pending dispatch, a yield that keeps the thread
//   and any request while halted go from accept through a result read to the
//   result load. Create, resume and kill walk the slot table one slot a cycle
//   and stop early on a hit. A dispatch adds a setup state, the scan and one
//   or two decision states; a kill of the running thread scans twice. A new
//   request is accepted only in the idle state, after the previous result
//   loads, so one request is in work at a time.
// Reset: slot 0 runs with id 0, all other slots are dead, clock and id
//   counter are zero. No clearing pass is needed.
// Stall: a finished result waits in the output register; the next request
//   is still accepted and processed, and its result is held back until the
//   waiting one is taken.
module round_robin_thread_scheduler_core #(
    parameter int SLOT_COUNT = 32,
    parameter int TIME_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rrts_req_if.sink                      req,
    rrts_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrts_pkg::PADDR_W-1:0]  paddr,
    input  logic [rrts_pkg::APB_DW-1:0]   pwdata,
    output logic [rrts_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    rrts_pkg::cmd_t                cmd;
    rrts_pkg::stat_t               stat;
    logic [rrts_pkg::QUANT_W-1:0]  quantum_reg;
    logic                          sel_quantum;

    // register index is the byte address over four
    assign sel_quantum = (paddr[rrts_pkg::PADDR_W-1:2] == rrts_pkg::REG_QUANTUM);
    assign pready      = 1'b1;
    assign prdata      = sel_quantum ? rrts_pkg::APB_DW'(quantum_reg) : '0;

    // hold quantum until written; ignore writes to unmapped addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= rrts_pkg::QUANTUM_RESET;
        end
        else if (psel && penable && pwrite && sel_quantum)
        begin
            quantum_reg <= pwdata[rrts_pkg::QUANT_W-1:0];
        end
    end

    // sequence commands and dispatch decisions
    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_kind   (req.kind),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // slot tables, scan unit and result register
    rrts_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_target_id (req.target_id),
        .in_sleep_ms  (req.sleep_ms),
        .quantum      (quantum_reg),
        .status       (rsp.status),
        .running_slot (rsp.running_slot),
        .running_id   (rsp.running_id),
        .created_id   (rsp.created_id)
    );

endmodule

/* design/rrts_dpath.sv */
// Scheduler datapath: slot tables, clock, id counter, scan unit, result register.
// Depends on rrts_pkg; driven by rrts_ctrl through cmd_t, reports through stat_t.
module rrts_dpath #(
    parameter int SLOT_COUNT = 32,
    parameter int TIME_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrts_pkg::cmd_t                cmd,
    output rrts_pkg::stat_t               stat,
    input  logic [rrts_pkg::ID_W-1:0]     in_target_id,
    input  logic [rrts_pkg::SLEEP_W-1:0]  in_sleep_ms,
    input  logic [rrts_pkg::QUANT_W-1:0]  quantum,
    output logic [rrts_pkg::STATUS_W-1:0] status,
    output logic [rrts_pkg::RSLOT_W-1:0]  running_slot,
    output logic [rrts_pkg::ID_W-1:0]     running_id,
    output logic [rrts_pkg::ID_W-1:0]     created_id
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] LAST_CNT  = CW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] ALL_CNT   = CW'(SLOT_COUNT);

    // slot tables
    logic [rrts_pkg::MODE_W-1:0] mode_mem  [SLOT_COUNT];
    logic [rrts_pkg::ID_W-1:0]   ident_mem [SLOT_COUNT];
    logic [TIME_BITS-1:0]        start_mem [SLOT_COUNT];
    logic [TIME_BITS-1:0]        wake_mem  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]       ident_vld_reg;
    logic [SLOT_COUNT-1:0]       start_vld_reg;

    // scalar state
    logic [SW-1:0]               active_reg;
    logic [rrts_pkg::ID_W-1:0]   counter_reg;
    logic [TIME_BITS-1:0]        clock_reg;
    logic [rrts_pkg::ID_W-1:0]   tid_reg;
    logic [rrts_pkg::SLEEP_W-1:0] sleep_reg;
    logic [rrts_pkg::ID_W-1:0]   created_reg;

    // scan unit
    logic [SW-1:0] pos_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0]    skind_reg;
    logic          live_reg;
    logic          done_reg;
    logic          hit_reg;
    logic [SW-1:0] hit_addr_reg;
    logic          saw_sleep_reg;
    logic          saw_susp_reg;

    // registered read port
    logic                        q_vld_reg;
    logic                        q_last_reg;
    logic [SW-1:0]               q_addr_reg;
    logic [rrts_pkg::MODE_W-1:0] q_mode_reg;
    logic [rrts_pkg::ID_W-1:0]   q_ident_mem_reg;
    logic                        q_ident_vld_reg;
    logic [TIME_BITS-1:0]        q_start_mem_reg;
    logic                        q_start_vld_reg;
    logic [TIME_BITS-1:0]        q_wake_reg;

    // result register
    logic [rrts_pkg::STATUS_W-1:0] out_status_reg;
    logic [rrts_pkg::RSLOT_W-1:0]  out_slot_reg;
    logic [rrts_pkg::ID_W-1:0]     out_id_reg;
    logic [rrts_pkg::ID_W-1:0]     out_created_reg;

    logic                        scan_issue;
    logic                        rd_en;
    logic [SW-1:0]               rd_addr;
    logic [SW-1:0]               next_after_active;
    logic [SW-1:0]               pos_inc;
    logic                        eval;
    logic                        match;
    logic [rrts_pkg::ID_W-1:0]   q_ident;
    logic [TIME_BITS-1:0]        q_start;
    logic [TIME_BITS-1:0]        wake_diff;
    logic [TIME_BITS-1:0]        elapsed;
    logic                        mode_we;
    logic [SW-1:0]               mode_waddr;
    logic [rrts_pkg::MODE_W-1:0] mode_wdata;
    logic                        ident_we;
    logic                        start_we;
    logic [SW-1:0]               start_waddr;
    logic                        wake_we;
    logic [SW+rrts_pkg::RSLOT_W-1:0] active_ext;

    assign scan_issue        = live_reg && (cnt_reg != ALL_CNT);
    assign rd_en             = scan_issue || (cmd.op == rrts_pkg::OP_RD_CUR);
    assign rd_addr           = scan_issue ? pos_reg : active_reg;
    assign next_after_active = (active_reg == LAST_SLOT) ? '0 : active_reg + SW'(1);
    assign pos_inc           = (pos_reg == LAST_SLOT) ? '0 : pos_reg + SW'(1);
    assign eval              = live_reg && q_vld_reg;
    assign q_ident           = q_ident_vld_reg ? q_ident_mem_reg : '0;
    assign q_start           = q_start_vld_reg ? q_start_mem_reg : '0;
    assign wake_diff         = q_wake_reg - clock_reg;
    assign elapsed           = clock_reg - q_start;
    assign active_ext        = {{rrts_pkg::RSLOT_W{1'b0}}, active_reg};

    always_comb
    begin
        case (skind_reg)
            rrts_pkg::SK_DISP:
                match = (q_mode_reg == rrts_pkg::M_READY) ||
                        ((q_mode_reg == rrts_pkg::M_SLEEP) && wake_diff[TIME_BITS-1]);
            rrts_pkg::SK_DEAD:
                match = (q_mode_reg == rrts_pkg::M_DEAD);
            rrts_pkg::SK_RESUME:
                match = (q_ident == tid_reg) && (q_mode_reg == rrts_pkg::M_SUSP);
            default:
                match = (q_ident == tid_reg) && (q_mode_reg != rrts_pkg::M_DEAD);
        endcase
    end

    always_comb
    begin
        stat.scan_done  = done_reg;
        stat.scan_hit   = hit_reg;
        stat.hit_is_cur = (hit_addr_reg == active_reg);
        stat.cur_run    = (q_mode_reg == rrts_pkg::M_RUN);
        stat.yield_due  = (q_mode_reg == rrts_pkg::M_RUN) &&
                          (elapsed >= TIME_BITS'(quantum));
        stat.saw_sleep  = saw_sleep_reg;
        stat.saw_susp   = saw_susp_reg;
    end

    // table write decode
    always_comb
    begin
        mode_we     = 1'b0;
        mode_waddr  = active_reg;
        mode_wdata  = cmd.mode_wdata;
        ident_we    = 1'b0;
        start_we    = 1'b0;
        start_waddr = active_reg;
        wake_we     = 1'b0;
        case (cmd.op)
            rrts_pkg::OP_SET_CUR:
            begin
                mode_we = 1'b1;
                wake_we = cmd.wake_we;
            end
            rrts_pkg::OP_HIT_MODE:
            begin
                mode_we    = 1'b1;
                mode_waddr = hit_addr_reg;
            end
            rrts_pkg::OP_CREATE_WR:
            begin
                mode_we     = 1'b1;
                mode_waddr  = hit_addr_reg;
                mode_wdata  = rrts_pkg::M_READY;
                ident_we    = 1'b1;
                start_we    = 1'b1;
                start_waddr = hit_addr_reg;
            end
            rrts_pkg::OP_DISP_OLD:
            begin
                mode_we    = (q_mode_reg == rrts_pkg::M_RUN) && (hit_addr_reg != active_reg);
                mode_wdata = rrts_pkg::M_READY;
            end
            rrts_pkg::OP_DISP_NEW:
            begin
                mode_we     = 1'b1;
                mode_waddr  = hit_addr_reg;
                mode_wdata  = rrts_pkg::M_RUN;
                start_we    = 1'b1;
                start_waddr = hit_addr_reg;
            end
            rrts_pkg::OP_KEEP:
            begin
                start_we = 1'b1;
            end
            default:
            begin
                mode_we = 1'b0;
            end
        endcase
    end

    // mode table: flops with known reset, slot zero running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                mode_mem[i] <= (i == 0) ? rrts_pkg::M_RUN : rrts_pkg::M_DEAD;
            end
        end
        else if (mode_we)
        begin
            mode_mem[mode_waddr] <= mode_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_vld_reg <= '0;
            start_vld_reg <= '0;
        end
        else
        begin
            if (ident_we)
            begin
                ident_vld_reg[hit_addr_reg] <= 1'b1;
            end
            if (start_we)
            begin
                start_vld_reg[start_waddr] <= 1'b1;
            end
        end
    end

    // id, start and wake memories
    always_ff @(posedge clk)
    begin
        if (ident_we)
        begin
            ident_mem[hit_addr_reg] <= counter_reg + rrts_pkg::ID_W'(1);
        end
        if (start_we)
        begin
            start_mem[start_waddr] <= clock_reg;
        end
        if (wake_we)
        begin
            wake_mem[active_reg] <= clock_reg + TIME_BITS'(sleep_reg);
        end
        if (rd_en)
        begin
            q_addr_reg      <= rd_addr;
            q_mode_reg      <= mode_mem[rd_addr];
            q_ident_mem_reg <= ident_mem[rd_addr];
            q_ident_vld_reg <= ident_vld_reg[rd_addr];
            q_start_mem_reg <= start_mem[rd_addr];
            q_start_vld_reg <= start_vld_reg[rd_addr];
            q_wake_reg      <= wake_mem[rd_addr];
        end
    end

    // scalar state and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            counter_reg <= '0;
            clock_reg   <= '0;
            live_reg    <= 1'b0;
            done_reg    <= 1'b0;
            q_vld_reg   <= 1'b0;
            q_last_reg  <= 1'b0;
        end
        else
        begin
            q_vld_reg  <= scan_issue;
            q_last_reg <= scan_issue && (cnt_reg == LAST_CNT);
            case (cmd.op)
                rrts_pkg::OP_TICK:      clock_reg   <= clock_reg + TIME_BITS'(1);
                rrts_pkg::OP_CREATE_WR: counter_reg <= counter_reg + rrts_pkg::ID_W'(1);
                rrts_pkg::OP_DISP_NEW:  active_reg  <= hit_addr_reg;
                default:                active_reg  <= active_reg;
            endcase
            if (cmd.op == rrts_pkg::OP_SCAN_INIT)
            begin
                live_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (eval && (match || q_last_reg))
            begin
                live_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // scan payload (position, count, hit, summary flags), request latch and result register
    always_ff @(posedge clk)
    begin
        if (cmd.op == rrts_pkg::OP_SCAN_INIT)
        begin
            pos_reg       <= ((cmd.skind == rrts_pkg::SK_DISP) ||
                              (cmd.skind == rrts_pkg::SK_DEAD)) ? next_after_active : '0;
            cnt_reg       <= '0;
            skind_reg     <= cmd.skind;
            hit_reg       <= 1'b0;
            saw_sleep_reg <= 1'b0;
            saw_susp_reg  <= 1'b0;
        end
        else
        begin
            if (scan_issue)
            begin
                pos_reg <= pos_inc;
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (eval)
            begin
                if (match)
                begin
                    hit_reg      <= 1'b1;
                    hit_addr_reg <= q_addr_reg;
                end
                else if (q_mode_reg == rrts_pkg::M_SLEEP)
                begin
                    saw_sleep_reg <= 1'b1;
                end
                else if (q_mode_reg == rrts_pkg::M_SUSP)
                begin
                    saw_susp_reg <= 1'b1;
                end
            end
        end
        if (cmd.op == rrts_pkg::OP_LATCH)
        begin
            tid_reg     <= in_target_id;
            sleep_reg   <= in_sleep_ms;
            created_reg <= '0;
        end
        else if (cmd.op == rrts_pkg::OP_CREATE_WR)
        begin
            created_reg <= counter_reg + rrts_pkg::ID_W'(1);
        end
        if (cmd.op == rrts_pkg::OP_LOAD_OUT)
        begin
            out_status_reg  <= cmd.status;
            out_slot_reg    <= active_ext[rrts_pkg::RSLOT_W-1:0];
            out_id_reg      <= (q_mode_reg == rrts_pkg::M_RUN) ? q_ident : '0;
            out_created_reg <= created_reg;
        end
    end

    assign status       = out_status_reg;
    assign running_slot = out_slot_reg;
    assign running_id   = out_id_reg;
    assign created_id   = out_created_reg;

endmodule

/* design/rrts_ctrl.sv */
// Scheduler controller: command sequencing, dispatch decisions, handshakes.
// Depends on rrts_pkg and the assertion macro header; drives rrts_dpath.
`include "round_robin_thread_scheduler_core_defines.svh"
module rrts_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rrts_pkg::KIND_W-1:0]   in_kind,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  rrts_pkg::stat_t               stat,
    output rrts_pkg::cmd_t                cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_YCHK     = 4'd2;
    localparam logic [3:0] S_DSP_INIT = 4'd3;
    localparam logic [3:0] S_SCAN     = 4'd4;
    localparam logic [3:0] S_DSP_DEC  = 4'd5;
    localparam logic [3:0] S_DSP_NEW  = 4'd6;
    localparam logic [3:0] S_FIN_RD   = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0]                    state_reg, state_next;
    logic [rrts_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic                          disp_reg, disp_next;
    logic                          pending_reg, pending_next;
    logic                          halted_reg, halted_next;
    logic [rrts_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          out_vld_reg, out_vld_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_vld_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        disp_next      = disp_reg;
        pending_next   = pending_reg;
        halted_next    = halted_reg;
        status_next    = status_reg;
        out_vld_next   = out_vld_reg && !out_ready;
        cmd.op         = rrts_pkg::OP_NONE;
        cmd.skind      = rrts_pkg::SK_DISP;
        cmd.mode_wdata = rrts_pkg::M_DEAD;
        cmd.wake_we    = 1'b0;
        cmd.status     = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = rrts_pkg::OP_LATCH;
                    kind_next  = in_kind;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_FIN_RD;
                if (halted_reg)
                begin
                    status_next = rrts_pkg::ST_HALTED;
                end
                else if (kind_reg == rrts_pkg::K_TICK)
                begin
                    cmd.op = rrts_pkg::OP_TICK;
                    if (pending_reg)
                    begin
                        state_next = S_DSP_INIT;
                    end
                    else
                    begin
                        status_next = rrts_pkg::ST_DONE;
                    end
                end
                else if (kind_reg == rrts_pkg::K_RESUME || kind_reg == rrts_pkg::K_KILL)
                begin
                    cmd.op     = rrts_pkg::OP_SCAN_INIT;
                    cmd.skind  = (kind_reg == rrts_pkg::K_RESUME) ? rrts_pkg::SK_RESUME
                                                                  : rrts_pkg::SK_KILL;
                    disp_next  = 1'b0;
                    state_next = S_SCAN;
                end
                else if (pending_reg)
                begin
                    status_next = rrts_pkg::ST_WAIT;
                end
                else
                begin
                    case (kind_reg)
                        rrts_pkg::K_CREATE:
                        begin
                            cmd.op     = rrts_pkg::OP_SCAN_INIT;
                            cmd.skind  = rrts_pkg::SK_DEAD;
                            disp_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        rrts_pkg::K_EXIT:
                        begin
                            cmd.op         = rrts_pkg::OP_SET_CUR;
                            cmd.mode_wdata = rrts_pkg::M_DEAD;
                            state_next     = S_DSP_INIT;
                        end
                        rrts_pkg::K_SUSPEND:
                        begin
                            cmd.op         = rrts_pkg::OP_SET_CUR;
                            cmd.mode_wdata = rrts_pkg::M_SUSP;
                            state_next     = S_DSP_INIT;
                        end
                        rrts_pkg::K_SLEEP:
                        begin
                            cmd.op         = rrts_pkg::OP_SET_CUR;
                            cmd.mode_wdata = rrts_pkg::M_SLEEP;
                            cmd.wake_we    = 1'b1;
                            state_next     = S_DSP_INIT;
                        end
                        rrts_pkg::K_YIELD:
                        begin
                            cmd.op     = rrts_pkg::OP_RD_CUR;
                            state_next = S_YCHK;
                        end
                        default:
                        begin
                            status_next = rrts_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_YCHK:
            begin
                if (stat.yield_due)
                begin
                    state_next = S_DSP_INIT;
                end
                else
                begin
                    status_next = rrts_pkg::ST_KEPT;
                    state_next  = S_FIN_RD;
                end
            end
            S_DSP_INIT:
            begin
                cmd.op     = rrts_pkg::OP_SCAN_INIT;
                cmd.skind  = rrts_pkg::SK_DISP;
                disp_next  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FIN_RD;
                    if (disp_reg)
                    begin
                        cmd.op     = rrts_pkg::OP_RD_CUR;
                        state_next = S_DSP_DEC;
                    end
                    else if (!stat.scan_hit)
                    begin
                        status_next = (kind_reg == rrts_pkg::K_CREATE) ? rrts_pkg::ST_NOCREATE
                                                                       : rrts_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        status_next = rrts_pkg::ST_DONE;
                        case (kind_reg)
                            rrts_pkg::K_CREATE:
                            begin
                                cmd.op = rrts_pkg::OP_CREATE_WR;
                            end
                            rrts_pkg::K_RESUME:
                            begin
                                cmd.op         = rrts_pkg::OP_HIT_MODE;
                                cmd.mode_wdata = rrts_pkg::M_READY;
                            end
                            default:
                            begin
                                // kill: switch away only when the victim was running
                                cmd.op         = rrts_pkg::OP_HIT_MODE;
                                cmd.mode_wdata = rrts_pkg::M_DEAD;
                                if (stat.hit_is_cur && !pending_reg)
                                begin
                                    state_next = S_DSP_INIT;
                                end
                            end
                        endcase
                    end
                end
            end
            S_DSP_DEC:
            begin
                state_next = S_FIN_RD;
                if (stat.scan_hit)
                begin
                    cmd.op     = rrts_pkg::OP_DISP_OLD;
                    state_next = S_DSP_NEW;
                end
                else if (stat.cur_run)
                begin
                    cmd.op       = rrts_pkg::OP_KEEP;
                    pending_next = 1'b0;
                    status_next  = rrts_pkg::ST_KEPT;
                end
                else if (stat.saw_sleep)
                begin
                    pending_next = 1'b1;
                    status_next  = rrts_pkg::ST_WAIT;
                end
                else
                begin
                    pending_next = 1'b0;
                    halted_next  = 1'b1;
                    status_next  = stat.saw_susp ? rrts_pkg::ST_SUSPHALT
                                                 : rrts_pkg::ST_FINHALT;
                end
            end
            S_DSP_NEW:
            begin
                cmd.op       = rrts_pkg::OP_DISP_NEW;
                pending_next = 1'b0;
                status_next  = rrts_pkg::ST_SWITCH;
                state_next   = S_FIN_RD;
            end
            S_FIN_RD:
            begin
                cmd.op     = rrts_pkg::OP_RD_CUR;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    cmd.op       = rrts_pkg::OP_LOAD_OUT;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            kind_reg    <= rrts_pkg::K_TICK;
            disp_reg    <= 1'b0;
            pending_reg <= 1'b0;
            halted_reg  <= 1'b0;
            status_reg  <= rrts_pkg::ST_DONE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            disp_reg    <= disp_next;
            pending_reg <= pending_next;
            halted_reg  <= halted_next;
            status_reg  <= status_next;
            out_vld_reg <= out_vld_next;
        end
    end

    `RRTS_ASSERT_NXT(a_halt_sticky, halted_reg, halted_reg)
    `RRTS_ASSERT_IMP(a_halt_not_waiting, halted_reg, !pending_reg)
    `RRTS_ASSERT_NXT(a_halted_reports, (state_reg == S_START) && halted_reg, status_reg == rrts_pkg::ST_HALTED)

endmodule
